// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 / UTF-32 code point decoder.
package u8d_pkg;

	localparam int unsigned Q_DEPTH = 2;	// power of two, pointers wrap freely
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_WIDE_MODE      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SWAP_ORDER     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INVALID_MARKER = 2'd2;

	localparam logic [31:0] INVALID_MARKER_RST = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT,
		CLS_BAD
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       text_end;
		cls_t       cls;
	} item_t;

	typedef struct packed {
		logic [31:0] code_point;
		logic        invalid;
		logic [2:0]  seq_bytes;
		logic        final_result;
	} res_t;

	typedef struct packed {
		logic        wide_mode;
		logic        swap_order;
		logic [31:0] invalid_marker;
	} cfg_t;

endpackage

// ===== rtl/u8d_front.sv =====
// Front end: byte classification and the input queue toward the decoder.
module u8d_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     data_byte,
	input  logic           text_end,
	output logic           avail,
	output u8d_pkg::item_t head,
	input  logic           deq
);
	import u8d_pkg::*;

	item_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wptr_q;
	logic [Q_PTR_W-1:0]  rptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                enq;
	logic                deq_ok;
	cls_t                cls;

	always_comb begin
		if (data_byte inside {[8'h00:8'h7F]}) begin
			cls = CLS_ASCII;
		end else if (data_byte inside {[8'h80:8'hBF]}) begin
			cls = CLS_CONT;
		end else if (data_byte inside {[8'hC0:8'hDF]}) begin
			cls = CLS_LEAD2;
		end else if (data_byte inside {[8'hE0:8'hEF]}) begin
			cls = CLS_LEAD3;
		end else if (data_byte inside {[8'hF0:8'hF7]}) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_BAD;
		end
	end

	assign full   = (cnt_q == Q_FULL_CNT);
	assign avail  = (cnt_q != '0);
	assign enq    = push && !full;
	assign deq_ok = deq && avail;
	assign head   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem[wptr_q] <= '{data_byte: data_byte, text_end: text_end, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (enq) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (deq_ok) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(enq) - Q_CNT_W'(deq_ok);
		end
	end

endmodule

// ===== rtl/u8d_back.sv =====
// Back end: sequence decoder state and the result queue.
module u8d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  u8d_pkg::cfg_t  cfg,
	input  logic           cfg_clr,
	input  logic           avail,
	input  u8d_pkg::item_t head,
	output logic           take,
	output logic           empty,
	input  logic           pop,
	output u8d_pkg::res_t  res
);
	import u8d_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COLLECT,
		PH_DROP
	} phase_t;

	phase_t              phase_q, nxt_phase;
	logic [1:0]          left_q, nxt_left;
	logic [2:0]          len_q, nxt_len;
	logic [31:0]         acc_q, nxt_acc;

	res_t                mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wptr_q;
	logic [Q_PTR_W-1:0]  rptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                pop_ok;
	logic                emit;
	res_t                emit_res;

	logic [31:0]         w_acc;
	logic [2:0]          w_len;
	logic [1:0]          w_left;
	logic [31:0]         n_acc;
	logic [1:0]          n_left;
	logic [7:0]          b;
	logic                at_end;

	assign pop_ok = pop && (cnt_q != '0);
	assign take   = avail && ((cnt_q != Q_FULL_CNT) || pop_ok);
	assign empty  = (cnt_q == '0);
	assign res    = mem[rptr_q];
	assign b      = head.data_byte;
	assign at_end = head.text_end;

	always_comb begin
		nxt_phase = phase_q;
		nxt_left  = left_q;
		nxt_len   = len_q;
		nxt_acc   = acc_q;
		emit      = 1'b0;
		emit_res  = '0;

		// UTF-32 gather step
		if (phase_q != PH_COLLECT) begin
			w_acc  = {24'd0, b};
			w_len  = 3'd1;
			w_left = 2'd3;
		end else begin
			w_acc  = cfg.swap_order ? {acc_q[23:0], b}
				: (acc_q | ({24'd0, b} << {len_q[1:0], 3'b000}));
			w_len  = len_q + 3'd1;
			w_left = left_q - 2'd1;
		end

		// UTF-8 continuation step
		n_acc  = {acc_q[25:0], b[5:0]};
		n_left = left_q - 2'd1;

		if (take) begin
			if (phase_q == PH_DROP) begin
				if (at_end) begin
					nxt_phase = PH_IDLE;
				end
			end else begin
				// default outcome: invalid result, sequence state cleared
				emit_res = '{code_point: '0, invalid: 1'b1, seq_bytes: '0,
					final_result: 1'b1};
				if (cfg.wide_mode) begin
					if (w_len == 3'd4) begin
						emit = 1'b1;
						if (w_acc != cfg.invalid_marker) begin
							emit_res = '{code_point: w_acc, invalid: 1'b0,
								seq_bytes: 3'd4, final_result: at_end};
						end
					end else if (at_end) begin
						emit = 1'b1;
					end else begin
						nxt_phase = PH_COLLECT;
						nxt_acc   = w_acc;
						nxt_len   = w_len;
						nxt_left  = w_left;
					end
				end else if (phase_q != PH_COLLECT) begin
					case (head.cls)
						CLS_ASCII: begin
							emit = 1'b1;
							emit_res = '{code_point: {25'd0, b[6:0]}, invalid: 1'b0,
								seq_bytes: 3'd1, final_result: at_end};
						end
						CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
							if (at_end) begin
								emit = 1'b1;
							end else begin
								nxt_phase = PH_COLLECT;
								case (head.cls)
									CLS_LEAD2: begin
										nxt_acc  = {27'd0, b[4:0]};
										nxt_len  = 3'd2;
										nxt_left = 2'd1;
									end
									CLS_LEAD3: begin
										nxt_acc  = {28'd0, b[3:0]};
										nxt_len  = 3'd3;
										nxt_left = 2'd2;
									end
									default: begin
										nxt_acc  = {29'd0, b[2:0]};
										nxt_len  = 3'd4;
										nxt_left = 2'd3;
									end
								endcase
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end else if (head.cls != CLS_CONT) begin
					emit = 1'b1;
				end else if (n_left == 2'd0) begin
					emit = 1'b1;
					emit_res = '{code_point: n_acc, invalid: 1'b0,
						seq_bytes: len_q, final_result: at_end};
				end else if (at_end) begin
					emit = 1'b1;
				end else begin
					nxt_acc  = n_acc;
					nxt_left = n_left;
				end

				if (emit) begin
					nxt_acc  = '0;
					nxt_len  = '0;
					nxt_left = '0;
					// an invalid result mid-text drops bytes until the end
					nxt_phase = (emit_res.invalid && !at_end) ? PH_DROP : PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mem[wptr_q] <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			wptr_q  <= '0;
			rptr_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_clr) begin
				phase_q <= PH_IDLE;
				left_q  <= '0;
				len_q   <= '0;
				acc_q   <= '0;
			end else begin
				phase_q <= nxt_phase;
				left_q  <= nxt_left;
				len_q   <= nxt_len;
				acc_q   <= nxt_acc;
			end
			if (emit) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (pop_ok) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(emit) - Q_CNT_W'(pop_ok);
		end
	end

endmodule

// ===== rtl/utf8_utf32_codepoint_decoder_core.sv =====
// A pushed byte is registered in the input queue, then decoded into the result queue.
// Throughput: the decoder takes one byte per cycle while the result queue has room.
// Both sides hold two-entry queues, so push and pop stall independently.
// Reset (arst_n low, asynchronous): queues empty, decoder idle, registers wide_mode=0,
// swap_order=0, invalid_marker=0x7FFFFFFF. No clearing pass is needed.
module utf8_utf32_codepoint_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          text_end,
	output logic                          empty,
	input  logic                          pop,
	output logic [31:0]                   code_point,
	output logic                          invalid,
	output logic [2:0]                    seq_bytes,
	output logic                          final_result,
	input  logic                          wr_en,
	input  logic [u8d_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [31:0]                   wr_data
);
	import u8d_pkg::*;

	cfg_t  cfg_q;
	logic  cfg_clr;
	logic  avail;
	logic  take;
	item_t head;
	res_t  res;

	// mode changes abandon any partial sequence
	assign cfg_clr = wr_en && ((wr_index == REG_WIDE_MODE) || (wr_index == REG_SWAP_ORDER));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_mode      <= 1'b0;
			cfg_q.swap_order     <= 1'b0;
			cfg_q.invalid_marker <= INVALID_MARKER_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDE_MODE:      cfg_q.wide_mode      <= wr_data[0];
				REG_SWAP_ORDER:     cfg_q.swap_order     <= wr_data[0];
				REG_INVALID_MARKER: cfg_q.invalid_marker <= wr_data;
				default: ;
			endcase
		end
	end

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.text_end  (text_end),
		.avail     (avail),
		.head      (head),
		.deq       (take)
	);

	u8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cfg_clr (cfg_clr),
		.avail   (avail),
		.head    (head),
		.take    (take),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign code_point   = res.code_point;
	assign invalid      = res.invalid;
	assign seq_bytes    = res.seq_bytes;
	assign final_result = res.final_result;

	a_invalid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && invalid) |-> (code_point == '0 && seq_bytes == '0 && final_result))
		else $error("invalid result carries payload");

	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !invalid) |-> (seq_bytes != '0 && seq_bytes <= 3'd4))
		else $error("valid result with bad byte count");

	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> avail)
		else $error("decoder took a byte from an empty queue");

	a_no_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !take) |=> empty)
		else $error("result appeared without a decoded byte");

endmodule

// ===== tb/utf8_utf32_codepoint_decoder_core_test.sv =====
// Self-checking testbench for the UTF-8 / UTF-32 code point decoder core.
module utf8_utf32_codepoint_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import u8d_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 40;

	typedef enum logic [1:0] {DEC_IDLE, DEC_COLLECT, DEC_DROP} dec_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       text_end;
	} text_byte_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [7:0]           data_byte = 8'd0;
	logic                 text_end = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [31:0]          code_point;
	logic                 invalid;
	logic [2:0]           seq_bytes;
	logic                 final_result;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [31:0]          wr_data = 32'd0;

	text_byte_t text_bytes[$];
	res_t       pending_cps[$];
	int         mismatches = 0;
	int         stall_cycles = 0;
	int         send_idle = 30;
	int         recv_idle = 46;

	// decoder state as predicted
	cfg_t        model_cfg;
	dec_phase_t  dec_phase;
	logic [1:0]  owed;
	logic [2:0]  seq_len;
	logic [31:0] acc;

	utf8_utf32_codepoint_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.text_end(text_end),
		.empty(empty),
		.pop(pop),
		.code_point(code_point),
		.invalid(invalid),
		.seq_bytes(seq_bytes),
		.final_result(final_result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void restart_seq();
		dec_phase = DEC_IDLE;
		owed = 2'd0;
		seq_len = 3'd0;
		acc = 32'd0;
	endfunction

	function automatic res_t cp_result(logic [31:0] cp, logic [2:0] n, logic fin);
		res_t r;
		r.code_point = cp;
		r.invalid = 1'b0;
		r.seq_bytes = n;
		r.final_result = fin;
		return r;
	endfunction

	// invalid result; bytes are dropped to end of text unless this byte ends it
	function automatic res_t bad_result(logic at_end);
		res_t r;
		restart_seq();
		if (!at_end)
			dec_phase = DEC_DROP;
		r.code_point = 32'd0;
		r.invalid = 1'b1;
		r.seq_bytes = 3'd0;
		r.final_result = 1'b1;
		return r;
	endfunction

	function automatic bit decode_step(input logic [7:0] b, input logic e, output res_t r);
		logic [31:0] word;
		logic [2:0]  n;
		r = '0;
		if (dec_phase == DEC_DROP) begin
			if (e)
				restart_seq();
			return 1'b0;
		end
		if (model_cfg.wide_mode) begin
			if (dec_phase != DEC_COLLECT) begin
				acc = {24'd0, b};
				seq_len = 3'd1;
				owed = 2'd3;
				dec_phase = DEC_COLLECT;
			end else begin
				if (model_cfg.swap_order)
					acc = {acc[23:0], b};
				else
					acc = acc | ({24'd0, b} << (8 * seq_len));
				seq_len = seq_len + 3'd1;
				owed = owed - 2'd1;
			end
			if (seq_len >= 3'd4) begin
				word = acc;
				restart_seq();
				if (word == model_cfg.invalid_marker)
					r = bad_result(e);
				else
					r = cp_result(word, 3'd4, e);
				return 1'b1;
			end
			if (e) begin
				r = bad_result(1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		if (dec_phase != DEC_COLLECT) begin
			if (!b[7]) begin
				restart_seq();
				r = cp_result({25'd0, b[6:0]}, 3'd1, e);
				return 1'b1;
			end else if (b[7:5] == 3'b110) begin
				acc = {27'd0, b[4:0]};
				seq_len = 3'd2;
			end else if (b[7:4] == 4'b1110) begin
				acc = {28'd0, b[3:0]};
				seq_len = 3'd3;
			end else if (b[7:3] == 5'b11110) begin
				acc = {29'd0, b[2:0]};
				seq_len = 3'd4;
			end else begin
				r = bad_result(e);
				return 1'b1;
			end
			owed = 2'(seq_len - 3'd1);
			dec_phase = DEC_COLLECT;
			if (e) begin
				r = bad_result(1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		if (b[7:6] != 2'b10) begin
			r = bad_result(e);
			return 1'b1;
		end
		acc = {acc[25:0], b[5:0]};
		owed = owed - 2'd1;
		if (owed == 2'd0) begin
			word = acc;
			n = seq_len;
			restart_seq();
			r = cp_result(word, n, e);
			return 1'b1;
		end
		if (e) begin
			r = bad_result(1'b1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	// monitor: output transfers are checked before the input transfer of the same edge
	always @(posedge clk) begin
		res_t want, fresh;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_cps.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result expected none got cp %h inv %b n %0d fin %b",
							$time, code_point, invalid, seq_bytes, final_result);
				end else begin
					want = pending_cps.pop_front();
					check_field("code_point", want.code_point, code_point);
					check_field("invalid", 32'(want.invalid), 32'(invalid));
					check_field("seq_bytes", 32'(want.seq_bytes), 32'(seq_bytes));
					check_field("final_result", 32'(want.final_result), 32'(final_result));
				end
			end
			if (push && !full) begin
				void'(text_bytes.pop_front());
				if (decode_step(data_byte, text_end, fresh))
					pending_cps.push_back(fresh);
			end
			if (wr_en) begin
				case (wr_index)
					REG_WIDE_MODE: begin
						model_cfg.wide_mode = wr_data[0];
						restart_seq();
					end
					REG_SWAP_ORDER: begin
						model_cfg.swap_order = wr_data[0];
						restart_seq();
					end
					REG_INVALID_MARKER: model_cfg.invalid_marker = wr_data;
					default: ;
				endcase
			end
		end
	end

	// driver: push and pop change at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle);
			if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				push <= 1'b1;
				data_byte <= text_bytes[0].data_byte;
				text_end <= text_bytes[0].text_end;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || wr_en) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL utf8_utf32_codepoint_decoder_core");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic void put_byte(logic [7:0] b, logic e);
		text_bytes.push_back('{data_byte: b, text_end: e});
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
	endtask

	task automatic finish_writes();
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// all bytes taken and all code points out, then room for a sequence still in flight
	task automatic wait_idle();
		while (text_bytes.size() != 0 || pending_cps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// UTF-8 texts: mostly well formed, with noise, bad leads, bad continuations and cuts
	function automatic void queue_utf8(int n);
		int         queued;
		int         ncp;
		int         sel;
		int         len;
		int         cut;
		bit         close;
		logic [7:0] seq[4];
		logic [31:0] bits;
		logic [7:0] junk;
		queued = 0;
		while (queued < n) begin
			ncp = $urandom_range(1, 6);
			close = ($urandom_range(0, 99) < 92);
			for (int i = 0; i < ncp; i++) begin
				sel = $urandom_range(0, 99);
				bits = $urandom;
				if (sel < 6) begin
					seq[0] = bits[7:0];
					len = 1;
				end else if (sel < 10) begin
					seq[0] = bits[8] ? 8'($urandom_range(8'h80, 8'hBF))
						: 8'($urandom_range(8'hF8, 8'hFF));
					len = 1;
				end else begin
					len = $urandom_range(1, 4);
					case (len)
						1: seq[0] = {1'b0, bits[6:0]};
						2: seq[0] = {3'b110, bits[10:6]};
						3: seq[0] = {4'b1110, bits[15:12]};
						default: seq[0] = {5'b11110, bits[20:18]};
					endcase
					seq[1] = {2'b10, len == 2 ? bits[5:0] : len == 3 ? bits[11:6] : bits[17:12]};
					seq[2] = {2'b10, len == 3 ? bits[5:0] : bits[11:6]};
					seq[3] = {2'b10, bits[5:0]};
					if (len > 1 && $urandom_range(0, 99) < 6) begin
						junk = 8'($urandom);
						if (junk[7:6] == 2'b10)
							junk[7] = 1'b0;
						seq[$urandom_range(1, len - 1)] = junk;
					end
				end
				cut = len;
				if (len > 1 && $urandom_range(0, 99) < 6)
					cut = $urandom_range(1, len - 1);
				for (int j = 0; j < cut; j++)
					put_byte(seq[j], j == cut - 1 && (cut < len || (i == ncp - 1 && close)));
				queued += cut;
				if (cut < len)
					break;
			end
		end
	endfunction

	// UTF-32 texts in the configured byte order; marker words and cut words mixed in
	function automatic void queue_utf32(int n);
		int          queued;
		int          nw;
		int          sel;
		int          cut;
		bit          close;
		logic [31:0] word;
		queued = 0;
		while (queued < n) begin
			nw = $urandom_range(1, 4);
			close = ($urandom_range(0, 99) < 90);
			for (int i = 0; i < nw; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 20)
					word = model_cfg.invalid_marker;
				else if (sel < 30)
					word = 32'($urandom_range(0, 255));
				else
					word = $urandom;
				cut = 4;
				if ($urandom_range(0, 99) < 8)
					cut = $urandom_range(1, 3);
				for (int j = 0; j < cut; j++)
					put_byte(model_cfg.swap_order ? word[8 * (3 - j) +: 8] : word[8 * j +: 8],
						j == cut - 1 && (cut < 4 || (i == nw - 1 && close)));
				queued += cut;
				if (cut < 4)
					break;
			end
		end
	endfunction

	initial begin
		model_cfg.wide_mode = 1'b0;
		model_cfg.swap_order = 1'b0;
		model_cfg.invalid_marker = INVALID_MARKER_RST;
		restart_seq();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset config, UTF-8: ASCII extremes, then sequences of two, three and four bytes (the last at its top value)
		put_byte(8'h00, 1'b0);
		put_byte(8'h7F, 1'b1);
		put_byte(8'hC2, 1'b0);
		put_byte(8'h80, 1'b1);
		put_byte(8'hE0, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b1);
		put_byte(8'hF7, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b1);
		// bad lead mid text, rest dropped up to end of text
		put_byte(8'h80, 1'b0);
		put_byte(8'h41, 1'b1);
		// bad lead on the final byte
		put_byte(8'hFF, 1'b1);
		// bad continuation, then dropping
		put_byte(8'hC3, 1'b0);
		put_byte(8'h41, 1'b0);
		put_byte(8'h42, 1'b1);
		// sequence cut short by end of text, also on the lead itself
		put_byte(8'hE2, 1'b0);
		put_byte(8'h82, 1'b1);
		put_byte(8'hF0, 1'b1);
		put_byte(8'hF8, 1'b1);
		// text left open
		put_byte(8'hDF, 1'b0);
		put_byte(8'hBF, 1'b0);
		wait_idle();

		write_reg(REG_WIDE_MODE, 32'd0);
		write_reg(REG_SWAP_ORDER, 32'd1);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		finish_writes();
		queue_utf8(200);
		wait_idle();

		write_reg(REG_WIDE_MODE, 32'd1);
		write_reg(REG_SWAP_ORDER, 32'd0);
		finish_writes();
		queue_utf32(120);
		wait_idle();

		send_idle = 46;
		recv_idle = 30;
		write_reg(REG_SWAP_ORDER, 32'd1);
		write_reg(REG_INVALID_MARKER, 32'd0);
		finish_writes();
		queue_utf32(120);
		wait_idle();

		// marker only: a partial word or dropping carries over
		write_reg(REG_INVALID_MARKER, 32'hFFFF_FFFF);
		finish_writes();
		queue_utf32(100);
		wait_idle();

		write_reg(REG_WIDE_MODE, 32'd0);
		finish_writes();
		queue_utf8(150);
		wait_idle();

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_WIDE_MODE, 32'd1);
		write_reg(REG_SWAP_ORDER, 32'd0);
		write_reg(REG_INVALID_MARKER, $urandom);
		finish_writes();
		queue_utf32(100);
		wait_idle();

		write_reg(REG_WIDE_MODE, 32'd0);
		write_reg(REG_INVALID_MARKER, INVALID_MARKER_RST);
		finish_writes();
		queue_utf8(150);
		wait_idle();

		if (mismatches == 0 && pending_cps.size() == 0)
			$display("PASS utf8_utf32_codepoint_decoder_core");
		else
			$display("FAIL utf8_utf32_codepoint_decoder_core");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_back.sv
rtl/utf8_utf32_codepoint_decoder_core.sv
tb/utf8_utf32_codepoint_decoder_core_test.sv
